[hw/rtl/transposition_table_probe_store_defines.svh]
// Assertion helpers used by the RTL of the probe/store table.
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define TTPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define TTPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ttps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ttps_pkg;

    localparam int SCORE_W = 17;

    // Operation codes
    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    // Bound kinds
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_ALPHA = 2'd1;
    localparam logic [1:0] BOUND_BETA  = 2'd2;

    localparam logic [15:0] MATE_RESET = 16'd48000;

    typedef logic signed [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic [63:0] key;
        logic [7:0]  depth;
        logic [1:0]  bound;
        score_t      score;
    } ttps_entry_t;

    typedef struct packed {
        logic        cmd;
        logic [63:0] key;
        logic [7:0]  depth;
        logic [7:0]  ply;
        score_t      score;
        logic [1:0]  bound;
        score_t      wlow;
        score_t      whigh;
    } ttps_item_t;

    // Per-stage load enables of the pipeline
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } ttps_adv_t;

endpackage

`default_nettype wire

[hw/rtl/ttps_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ttps_req_if;
    import ttps_pkg::*;

    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] position_key;
    logic [7:0]  search_depth;
    logic [7:0]  ply_count;
    score_t      entry_score;
    logic [1:0]  bound_kind;
    score_t      window_low;
    score_t      window_high;

    modport source (
        output valid, cmd, position_key, search_depth, ply_count,
               entry_score, bound_kind, window_low, window_high,
        input  ready
    );

    modport sink (
        input  valid, cmd, position_key, search_depth, ply_count,
               entry_score, bound_kind, window_low, window_high,
        output ready
    );
endinterface

interface ttps_rsp_if;
    import ttps_pkg::*;

    logic   valid;
    logic   ready;
    logic   hit;
    score_t result_score;

    modport source (
        output valid, hit, result_score,
        input  ready
    );

    modport sink (
        input  valid, hit, result_score,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/transposition_table_probe_store.sv]
// Direct-mapped, always-replace transposition table for a search engine.
// Request channel req (valid/ready) carries one word per probe or store:
// cmd, position_key, search_depth, ply_count, entry_score, bound_kind and
// the probe window. Response channel rsp returns one word per request, in
// order: hit and result_score (a store answers hit 0, score 0).
// Entry index is position_key mod ENTRIES; any ENTRIES in range works.
// Steps: a word accepted on req passes fold, reduce, table read, resolve
// and output before its response shows on rsp.
// Throughput: one word per clock when nothing stalls; the table has one read
// and one write port and a store writes as it passes the read stage, so
// back-to-back probe after store to the same entry sees the new data.
// Reset: rst_n clears the pipeline and returns mate_threshold to 48000,
// then a clear sweep writes zero to all ENTRIES entries, one per clock;
// req.ready stays low during the sweep. cfg writes are taken anytime
// but belong to idle periods.
// Stall: when rsp.ready is low the output word holds; the internal stages
// fill behind it and req.ready drops once all of them are occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "transposition_table_probe_store_defines.svh"

module transposition_table_probe_store #(
    parameter int ENTRIES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ttps_req_if.sink         req,
    ttps_rsp_if.source       rsp,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);
    import ttps_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic [15:0]   mate_reg;
    ttps_adv_t     adv;
    logic          adv_s1;
    logic          v1_reg;
    logic          v2_reg;
    logic          v3_reg;
    logic          v4_reg;
    logic          v5_reg;
    ttps_item_t    in_item;
    ttps_item_t    s1_item_reg;
    ttps_item_t    s2_item_next;
    ttps_item_t    s2_item_reg;
    ttps_item_t    s3_item_reg;
    ttps_item_t    s4_item_reg;
    score_t        store_adj;
    logic [IW-1:0] index;
    logic          tbl_busy;
    logic          tbl_wr_en;
    ttps_entry_t   tbl_wr_data;
    ttps_entry_t   tbl_rd_data;
    logic          probe_hit;
    score_t        probe_score;
    logic          hit_reg;
    score_t        score_reg;

    // Stage enables: a stage loads when it is empty or its successor moves.
    always_comb
    begin
        adv.s5 = !v5_reg || rsp.ready;
        adv.s4 = !v4_reg || adv.s5;
        adv.s3 = !v3_reg || adv.s4;
        adv.s2 = !v2_reg || adv.s3;
        adv_s1 = !v1_reg || adv.s2;
    end

    // Hold off requests during the clear sweep.
    assign req.ready = adv_s1 && !tbl_busy;

    always_comb
    begin
        in_item.cmd   = req.cmd;
        in_item.key   = req.position_key;
        in_item.depth = req.search_depth;
        in_item.ply   = req.ply_count;
        in_item.score = req.entry_score;
        in_item.bound = req.bound_kind;
        in_item.wlow  = req.window_low;
        in_item.whigh = req.window_high;
    end

    // Stage 2 carries the mate-adjusted store score.
    always_comb
    begin
        s2_item_next       = s1_item_reg;
        s2_item_next.score = store_adj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mate_reg <= MATE_RESET;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mate_reg <= cfg_wdata;
            end
            if (adv_s1)
            begin
                v1_reg <= req.valid && !tbl_busy;
            end
            if (adv.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv.s4)
            begin
                v4_reg <= v3_reg;
            end
            if (adv.s5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            s1_item_reg <= in_item;
        end
        if (adv.s2)
        begin
            s2_item_reg <= s2_item_next;
        end
        if (adv.s3)
        begin
            s3_item_reg <= s2_item_reg;
        end
        if (adv.s4)
        begin
            s4_item_reg <= s3_item_reg;
        end
        if (adv.s5)
        begin
            hit_reg   <= (s4_item_reg.cmd == CMD_PROBE) && probe_hit;
            score_reg <= (s4_item_reg.cmd == CMD_PROBE) ? probe_score : '0;
        end
    end

    // Key reduction runs over stages 1 to 3; the index is ready at stage 3.
    ttps_index #(
        .ENTRIES (ENTRIES)
    ) u_index (
        .clk   (clk),
        .adv   (adv),
        .key   (s1_item_reg.key),
        .index (index)
    );

    // A store writes its entry as it leaves stage 3; a probe reads there.
    always_comb
    begin
        tbl_wr_en         = adv.s4 && v3_reg && (s3_item_reg.cmd == CMD_STORE);
        tbl_wr_data.key   = s3_item_reg.key;
        tbl_wr_data.depth = s3_item_reg.depth;
        tbl_wr_data.bound = s3_item_reg.bound;
        tbl_wr_data.score = s3_item_reg.score;
    end

    ttps_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .busy    (tbl_busy),
        .rd_en   (adv.s4),
        .rd_addr (index),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (index),
        .wr_data (tbl_wr_data)
    );

    ttps_score u_score (
        .mate        (mate_reg),
        .store_score (s1_item_reg.score),
        .store_ply   (s1_item_reg.ply),
        .store_adj   (store_adj),
        .entry       (tbl_rd_data),
        .key         (s4_item_reg.key),
        .depth       (s4_item_reg.depth),
        .ply         (s4_item_reg.ply),
        .window_low  (s4_item_reg.wlow),
        .window_high (s4_item_reg.whigh),
        .hit         (probe_hit),
        .result      (probe_score)
    );

    assign rsp.valid        = v5_reg;
    assign rsp.hit          = hit_reg;
    assign rsp.result_score = score_reg;

    `TTPS_ASSERT_NOW(a_empty_while_clearing, clk, rst_n, tbl_busy,
        !v1_reg && !v2_reg && !v3_reg && !v4_reg && !v5_reg,
        "pipeline holds a word during the table clear")
    `TTPS_ASSERT_NOW(a_miss_scores_zero, clk, rst_n, rsp.valid && !rsp.hit,
        rsp.result_score == '0, "miss or store word carries a nonzero score")
    `TTPS_ASSERT_NEXT(a_stage4_holds, clk, rst_n, v4_reg && !adv.s5,
        v4_reg && $stable(s4_item_reg.key), "stage 4 word lost under output stall")

endmodule

`default_nettype wire

[hw/rtl/ttps_index.sv]
`timescale 1ns / 1ps
`default_nettype none

// key mod ENTRIES in two registered steps: fold the key bytes with their
// weights 2^(8b) mod ENTRIES, then reduce the fold by a reciprocal multiply
// and one corrective subtract.
module ttps_index #(
    parameter int ENTRIES = 65536
) (
    input  wire logic                        clk,
    input  wire ttps_pkg::ttps_adv_t         adv,
    input  wire logic [63:0]                 key,
    output logic [$clog2(ENTRIES)-1:0]       index
);
    localparam int IW = $clog2(ENTRIES);
    // fold <= 8 * 255 * (ENTRIES - 1) < 2^(IW + 11)
    localparam int SW = IW + 11;
    localparam int MW = 12;
    localparam int PW = SW + MW;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << SW) / ENTRIES);

    function automatic logic [63:0] byte_weight(input int pos);
        logic [63:0] w;
        w = 64'd1 % ENTRIES;
        for (int i = 0; i < pos; i++) begin
            w = (w * 64'd256) % ENTRIES;
        end
        return w;
    endfunction

    logic [SW-1:0] part [8];
    logic [SW-1:0] sum_next;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum3_reg;
    logic [MW-1:0] quot_reg;
    logic [PW-1:0] prod;
    logic [SW-1:0] qn;
    logic [SW-1:0] rem;
    logic [SW-1:0] rem_fix;

    for (genvar g = 0; g < 8; g++) begin : g_byte
        localparam logic [IW-1:0] WGT = IW'(byte_weight(g));
        assign part[g] = SW'(key[8*g +: 8]) * SW'(WGT);
    end

    always_comb
    begin
        sum_next = '0;
        for (int b = 0; b < 8; b++)
        begin
            sum_next = sum_next + part[b];
        end
    end

    // Quotient estimate never exceeds the true one and is short by at most one
    assign prod = PW'(sum_reg) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            sum_reg <= sum_next;
        end
        if (adv.s3)
        begin
            quot_reg <= prod[PW-1:SW];
            sum3_reg <= sum_reg;
        end
    end

    always_comb
    begin
        qn      = SW'(quot_reg) * SW'(ENTRIES);
        rem     = sum3_reg - qn;
        rem_fix = (rem >= SW'(ENTRIES)) ? rem - SW'(ENTRIES) : rem;
        index   = rem_fix[IW-1:0];
    end

endmodule

`default_nettype wire

[hw/rtl/ttps_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// Entry memory with one write and one registered read port.
// Sweep every entry to zero after reset, holding busy meanwhile.
module ttps_table #(
    parameter int ENTRIES = 65536
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    output logic                              busy,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0]   rd_addr,
    output ttps_pkg::ttps_entry_t             rd_data,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0]   wr_addr,
    input  wire ttps_pkg::ttps_entry_t        wr_data
);
    import ttps_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    ttps_entry_t   mem [ENTRIES];
    ttps_entry_t   rd_data_reg;
    logic          busy_reg;
    logic [IW-1:0] clr_addr_reg;
    logic [IW-1:0] clr_addr_next;
    logic          we;
    logic [IW-1:0] wa;
    ttps_entry_t   wd;

    assign clr_addr_next = clr_addr_reg + IW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_next;
            if (clr_addr_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        we = busy_reg || wr_en;
        wa = busy_reg ? clr_addr_reg : wr_addr;
        wd = busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign busy    = busy_reg;
    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/ttps_score.sv]
`timescale 1ns / 1ps
`default_nettype none

// Mate distance adjustment for stores, and hit test plus bound rule for probes.
module ttps_score (
    input  wire logic [15:0]            mate,
    input  wire ttps_pkg::score_t       store_score,
    input  wire logic [7:0]             store_ply,
    output ttps_pkg::score_t            store_adj,
    input  wire ttps_pkg::ttps_entry_t  entry,
    input  wire logic [63:0]            key,
    input  wire logic [7:0]             depth,
    input  wire logic [7:0]             ply,
    input  wire ttps_pkg::score_t       window_low,
    input  wire ttps_pkg::score_t       window_high,
    output logic                        hit,
    output ttps_pkg::score_t            result
);
    import ttps_pkg::*;

    localparam logic signed [18:0] SCORE_MIN = -19'sd65536;
    localparam logic signed [18:0] SCORE_MAX = 19'sd65535;

    function automatic score_t clamp(input logic signed [18:0] v);
        score_t r;
        if (v < SCORE_MIN)
        begin
            r = SCORE_MIN[SCORE_W-1:0];
        end
        else if (v > SCORE_MAX)
        begin
            r = SCORE_MAX[SCORE_W-1:0];
        end
        else
        begin
            r = v[SCORE_W-1:0];
        end
        return r;
    endfunction

    logic signed [18:0] mate_w;
    logic signed [18:0] sply_w;
    logic signed [18:0] pply_w;
    logic signed [18:0] st_w;
    logic signed [18:0] st_a;
    logic signed [18:0] st_b;
    logic signed [18:0] pr_w;
    logic signed [18:0] pr_a;
    logic signed [18:0] pr_b;
    score_t             pr_s;
    logic               match;

    always_comb
    begin
        mate_w = $signed({3'b000, mate});
        sply_w = $signed({11'b0, store_ply});
        pply_w = $signed({11'b0, ply});

        // push mate scores away from zero
        st_w      = 19'(store_score);
        st_a      = (st_w < -mate_w) ? st_w - sply_w : st_w;
        st_b      = (st_a > mate_w) ? st_a + sply_w : st_a;
        store_adj = clamp(st_b);

        // pull mate scores toward zero
        pr_w = 19'($signed(entry.score));
        pr_a = (pr_w < -mate_w) ? pr_w + pply_w : pr_w;
        pr_b = (pr_a > mate_w) ? pr_a - pply_w : pr_a;
        pr_s = clamp(pr_b);

        match  = (entry.key == key) && (entry.depth >= depth);
        hit    = 1'b0;
        result = '0;
        if (match)
        begin
            case (entry.bound)
                BOUND_EXACT:
                begin
                    hit    = 1'b1;
                    result = pr_s;
                end
                BOUND_ALPHA:
                begin
                    if (pr_s <= window_low)
                    begin
                        hit    = 1'b1;
                        result = window_low;
                    end
                end
                BOUND_BETA:
                begin
                    if (pr_s >= window_high)
                    begin
                        hit    = 1'b1;
                        result = window_high;
                    end
                end
                default:
                begin
                    hit    = 1'b0;
                    result = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ttps_pkg::*;

    localparam int ENTRIES   = 65536;
    localparam int IDX_W     = 16;
    localparam int SCORE_LO  = -65536;
    localparam int SCORE_HI  = 65535;
    localparam int CLK_HALF  = 2;
    localparam int KEY_POOL  = 40;
    localparam int POOL_W    = $clog2(KEY_POOL);

    // The fourth bound code has no name in the package; the table keeps it as is.
    localparam logic [1:0] BOUND_UNUSED = 2'd3;

    typedef struct packed {
        logic   hit;
        score_t score;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    ttps_req_if req_ch ();
    ttps_rsp_if rsp_ch ();

    transposition_table_probe_store #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the table and of mate_threshold.
    logic [63:0] tt_key   [ENTRIES];
    logic [7:0]  tt_depth [ENTRIES];
    logic [1:0]  tt_bound [ENTRIES];
    int          tt_score [ENTRIES];
    int          mate_limit;

    // Words waiting to be sent, and answers waiting to come back.
    ttps_item_t pending_words[$];
    answer_t    expected_answers[$];

    // Keys reused by the random part, with the score last stored under each.
    logic [63:0] key_pool   [KEY_POOL];
    int          last_score [KEY_POOL];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;

    ttps_item_t next_word;
    ttps_item_t seen_word;
    answer_t    want;

    // ------------------------------------------------------------------
    // Clock, reset and the time limit
    // ------------------------------------------------------------------
    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_PROBE;
        req_ch.position_key = '0;
        req_ch.search_depth = '0;
        req_ch.ply_count    = '0;
        req_ch.entry_score  = '0;
        req_ch.bound_kind   = BOUND_EXACT;
        req_ch.window_low   = '0;
        req_ch.window_high  = '0;
        rsp_ch.ready        = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Covers the clear sweep after reset plus every word at the slowest idling.
    initial
    begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int clamp_score(int v);
        if (v < SCORE_LO)
            return SCORE_LO;
        if (v > SCORE_HI)
            return SCORE_HI;
        return v;
    endfunction

    // Apply one word to the shadow table and return the answer it earns.
    function automatic answer_t probe_or_store(ttps_item_t w);
        logic [IDX_W-1:0] idx;
        int               ply;
        int               s;
        int               alpha;
        int               beta;
        answer_t          a;
        idx     = w.key[IDX_W-1:0];
        ply     = int'(w.ply);
        alpha   = $signed(w.wlow);
        beta    = $signed(w.whigh);
        a.hit   = 1'b0;
        a.score = '0;
        if (w.cmd == CMD_STORE)
        begin
            // Push a mate score away from zero, then overwrite the entry.
            s = $signed(w.score);
            if (s < -mate_limit)
                s = s - ply;
            if (s > mate_limit)
                s = s + ply;
            tt_key[idx]   = w.key;
            tt_depth[idx] = w.depth;
            tt_bound[idx] = w.bound;
            tt_score[idx] = clamp_score(s);
        end
        else if (tt_key[idx] == w.key && tt_depth[idx] >= w.depth)
        begin
            // Pull a mate score toward zero; the two tests run one after the other.
            s = tt_score[idx];
            if (s < -mate_limit)
                s = s + ply;
            if (s > mate_limit)
                s = s - ply;
            s = clamp_score(s);
            if (tt_bound[idx] == BOUND_EXACT)
            begin
                a.hit   = 1'b1;
                a.score = s[SCORE_W-1:0];
            end
            else if (tt_bound[idx] == BOUND_ALPHA && s <= alpha)
            begin
                a.hit   = 1'b1;
                a.score = w.wlow;
            end
            else if (tt_bound[idx] == BOUND_BETA && s >= beta)
            begin
                a.hit   = 1'b1;
                a.score = w.whigh;
            end
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int spread(int center, int width);
        return center + int'($urandom_range(2 * width)) - width;
    endfunction

    // Bias scores toward the mate threshold and the ends of the range.
    function automatic int random_score();
        case ($urandom_range(5))
            0: return spread(0, 2000);
            1: return spread(mate_limit, 300);
            2: return spread(-mate_limit, 300);
            3: return ($urandom_range(1) == 0) ? SCORE_LO : SCORE_HI;
            default: return int'($signed(17'($urandom)));
        endcase
    endfunction

    task automatic push_word(logic cmd, logic [63:0] key, int depth, int ply,
                             int score, logic [1:0] bound, int wlow, int whigh);
        ttps_item_t w;
        w.cmd   = cmd;
        w.key   = key;
        w.depth = depth[7:0];
        w.ply   = ply[7:0];
        w.score = score[SCORE_W-1:0];
        w.bound = bound;
        w.wlow  = wlow[SCORE_W-1:0];
        w.whigh = whigh[SCORE_W-1:0];
        pending_words.push_back(w);
    endtask

    // Mostly stores and probes on a small key pool, so probes find their
    // stores; windows sit around the last stored score to exercise bounds.
    function automatic ttps_item_t random_word();
        ttps_item_t        w;
        logic [POOL_W-1:0] slot;
        int                s;
        int                center;
        slot    = POOL_W'($urandom_range(KEY_POOL - 1));
        w.cmd   = ($urandom_range(99) < 40) ? CMD_STORE : CMD_PROBE;
        w.key   = ($urandom_range(99) < 88) ? key_pool[slot] : {$urandom, $urandom};
        w.depth = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(12));
        w.ply   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(24));
        w.bound = ($urandom_range(24) == 0) ? BOUND_UNUSED : 2'($urandom_range(2));
        s       = clamp_score(random_score());
        w.score = s[SCORE_W-1:0];
        if (w.cmd == CMD_STORE && w.key == key_pool[slot])
            last_score[slot] = s;
        center = last_score[slot];
        if ($urandom_range(9) == 0)
        begin
            w.wlow  = 17'($urandom);
            w.whigh = 17'($urandom);
        end
        else
        begin
            s       = clamp_score(spread(center, 300));
            w.wlow  = s[SCORE_W-1:0];
            s       = clamp_score(spread(center, 300));
            w.whigh = s[SCORE_W-1:0];
        end
        return w;
    endfunction

    task automatic queue_random_words(int count);
        repeat (count) pending_words.push_back(random_word());
    endtask

    // Hold the sender until every queued word has been answered, then let
    // the pipeline settle. Sample between edges so the driver has settled.
    task automatic wait_for_quiet();
        while (pending_words.size() != 0 || req_ch.valid || expected_answers.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mate_threshold(logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mate_limit = int'(value);
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic queue_directed_words();
        logic [63:0] k_top;
        logic [63:0] k_bottom;
        logic [63:0] k_alpha;
        logic [63:0] k_beta;
        logic [63:0] k_odd;
        logic [63:0] k_mate;
        k_top    = 64'hFFFF_FFFF_FFFF_FFFF;
        k_bottom = 64'h8000_0000_0000_0001;
        k_alpha  = 64'h0123_4567_89AB_0003;
        k_beta   = 64'h0F1E_2D3C_4B5A_0004;
        k_odd    = 64'h5555_AAAA_5555_0005;
        k_mate   = 64'h7777_0000_1234_0006;

        // Cleared entry at index zero: key 0 depth 0 hits with score 0.
        push_word(CMD_PROBE, 64'd0, 0, 0, 0, BOUND_EXACT, 0, 0);
        // Same index, other key; then the right key but too deep.
        push_word(CMD_PROBE, 64'h0000_0000_0001_0000, 0, 0, 0, BOUND_EXACT, 0, 0);
        push_word(CMD_PROBE, 64'd0, 1, 0, 0, BOUND_EXACT, 0, 0);

        // Top score pushed past the range on a store: saturate.
        push_word(CMD_STORE, k_top, 255, 255, SCORE_HI, BOUND_EXACT, 0, 0);
        push_word(CMD_PROBE, k_top, 255, 255, 0, BOUND_EXACT, SCORE_LO, SCORE_HI);
        push_word(CMD_PROBE, k_top, 0, 0, 0, BOUND_EXACT, 0, 0);

        // Bottom score, same story on the negative side.
        push_word(CMD_STORE, k_bottom, 10, 255, SCORE_LO, BOUND_EXACT, 0, 0);
        push_word(CMD_PROBE, k_bottom, 10, 255, 0, BOUND_EXACT, SCORE_HI, SCORE_LO);

        // Alpha bound: hit at equality, miss one below, miss when too deep.
        push_word(CMD_STORE, k_alpha, 5, 0, 100, BOUND_ALPHA, 0, 0);
        push_word(CMD_PROBE, k_alpha, 5, 0, 0, BOUND_EXACT, 100, 0);
        push_word(CMD_PROBE, k_alpha, 5, 0, 0, BOUND_EXACT, 99, 0);
        push_word(CMD_PROBE, k_alpha, 6, 0, 0, BOUND_EXACT, 100, 0);

        // Beta bound: hit at equality, miss one above.
        push_word(CMD_STORE, k_beta, 3, 0, -50, BOUND_BETA, 0, 0);
        push_word(CMD_PROBE, k_beta, 3, 0, 0, BOUND_EXACT, 0, -50);
        push_word(CMD_PROBE, k_beta, 3, 0, 0, BOUND_EXACT, 0, -49);

        // Bound kind three is kept but never answers.
        push_word(CMD_STORE, k_odd, 9, 0, 0, BOUND_UNUSED, 0, 0);
        push_word(CMD_PROBE, k_odd, 0, 0, 0, BOUND_EXACT, SCORE_HI, SCORE_LO);

        // Just above, at, and just below the mate threshold.
        push_word(CMD_STORE, k_mate, 4, 7, 48001, BOUND_EXACT, 0, 0);
        push_word(CMD_PROBE, k_mate, 4, 7, 0, BOUND_EXACT, 0, 0);
        push_word(CMD_STORE, k_mate, 4, 7, 48000, BOUND_EXACT, 0, 0);
        push_word(CMD_PROBE, k_mate, 4, 3, 0, BOUND_EXACT, 0, 0);
        push_word(CMD_STORE, k_mate, 4, 1, -48001, BOUND_EXACT, 0, 0);
        push_word(CMD_PROBE, k_mate, 4, 1, 0, BOUND_EXACT, 0, 0);

        // Overwrite the top entry and probe it with the widest window.
        push_word(CMD_STORE, k_top, 0, 0, 0, BOUND_ALPHA, SCORE_LO, SCORE_HI);
        push_word(CMD_PROBE, k_top, 0, 0, 0, BOUND_EXACT, SCORE_HI, SCORE_LO);
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        error_count = 0;
        mate_limit  = int'(MATE_RESET);
        for (int i = 0; i < ENTRIES; i++)
        begin
            tt_key[i]   = '0;
            tt_depth[i] = '0;
            tt_bound[i] = BOUND_EXACT;
            tt_score[i] = 0;
        end
        // Pairs of pool keys share an index but differ above it.
        for (int i = 0; i < KEY_POOL; i++)
        begin
            if (i % 2 == 1)
                key_pool[i] = {$urandom, 16'($urandom), key_pool[i-1][IDX_W-1:0]};
            else
                key_pool[i] = {$urandom, $urandom};
            last_score[i] = 0;
        end

        // Phase one: reset threshold, sender idles rarely, receiver stalls a lot.
        send_idle_pct  = 17;
        recv_stall_pct = 88;
        queue_directed_words();
        queue_random_words(383);
        wait_for_quiet();

        // Phase two: every nonzero score is a mate score; swap the idling.
        write_mate_threshold(16'd0);
        send_idle_pct  = 88;
        recv_stall_pct = 17;
        queue_random_words(383);
        wait_for_quiet();

        // Phase three: largest threshold, full rate on both sides.
        write_mate_threshold(16'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_words(192);
        wait_for_quiet();

        // Phase four: a threshold somewhere in between.
        write_mate_threshold(16'($urandom_range(60000, 1000)));
        queue_random_words(192);
        wait_for_quiet();

        if (expected_answers.size() != 0)
            report_mismatch($sformatf("%0d answers never arrived", expected_answers.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: advance to the next word once the current one is taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_word            = pending_words.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.cmd          <= next_word.cmd;
                req_ch.position_key <= next_word.key;
                req_ch.search_depth <= next_word.depth;
                req_ch.ply_count    <= next_word.ply;
                req_ch.entry_score  <= next_word.score;
                req_ch.bound_kind   <= next_word.bound;
                req_ch.window_low   <= next_word.wlow;
                req_ch.window_high  <= next_word.whigh;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response side back-pressure.
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted request, check each accepted response
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen_word.cmd   = req_ch.cmd;
                seen_word.key   = req_ch.position_key;
                seen_word.depth = req_ch.search_depth;
                seen_word.ply   = req_ch.ply_count;
                seen_word.score = req_ch.entry_score;
                seen_word.bound = req_ch.bound_kind;
                seen_word.wlow  = req_ch.window_low;
                seen_word.whigh = req_ch.window_high;
                expected_answers.push_back(probe_or_store(seen_word));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("response word with no request outstanding");
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp_ch.hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", rsp_ch.hit, want.hit));
                    if (rsp_ch.result_score !== want.score)
                        report_mismatch($sformatf("result_score %0d, want %0d",
                                                  rsp_ch.result_score, want.score));
                end
            end
        end
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ttps_pkg.sv
hw/rtl/ttps_if.sv
hw/rtl/ttps_index.sv
hw/rtl/ttps_table.sv
hw/rtl/ttps_score.sv
hw/rtl/transposition_table_probe_store.sv
tb/tb_top.sv
